@@ hdl/shc_pkg.sv @@
package shc_pkg;

   localparam int NumChips        = 16;
   localparam int ChannelsPerChip = 128;
   localparam int MaxHits         = 64;

   localparam int ChipW  = 4;
   localparam int ChanW  = 7;
   localparam int ValW   = 12;
   localparam int MapAw  = $clog2(NumChips * ChannelsPerChip);
   localparam int ChipAw = (NumChips > 1) ? $clog2(NumChips) : 1;
   localparam int HitAw  = $clog2(MaxHits);
   localparam int CntW   = HitAw + 1;
   localparam int ClusW  = 6;
   localparam int EntryW = 2 * ValW;

   typedef enum logic [1:0] {
      MODE_LOAD_MAP  = 2'd0,
      MODE_LOAD_CONN = 2'd1,
      MODE_HIT       = 2'd2,
      MODE_END       = 2'd3
   } mode_type;

endpackage

@@ hdl/shc_ram.sv @@
module shc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/strip_hit_clusterer_core.sv @@
// Strip hit clusterer.
// Input channel: an item (req_mode, req_chip_index, req_channel, req_hit_index,
// req_table_value) transfers at a clock edge where start is high and busy low.
// Modes: load strip map entry, load connector entry, hit, end of event.
// A load leaves busy low. A hit: strip map and connector reads through
// registered RAM ports, then the buffer write.
// End of event with N kept hits: insertion sort over the hit buffer, each
// compare or move going through the shared comparator and buffer port;
// then a labeling pass; then the output, one result per kept hit. The sort
// loop over one buffer port sets the event time.
// Results: rsp_* marked by rsp_valid for one cycle each; the receiver cannot
// stall them. An empty event gives no result and busy stays low.
// Reset (synchronous, active high) clears the hit count, overflow flag and
// sequencer; the strip map, connector table and hit buffer keep old contents
// and must be loaded before use.
module strip_hit_clusterer_core
   import shc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_mode,
   input  logic [shc_pkg::ChipW-1:0] req_chip_index,
   input  logic [shc_pkg::ChanW-1:0] req_channel,
   input  logic [shc_pkg::ValW-1:0]  req_hit_index,
   input  logic [shc_pkg::ValW-1:0]  req_table_value,
   output logic                      rsp_valid,
   output logic [shc_pkg::ValW-1:0]  rsp_out_hit_index,
   output logic [shc_pkg::ValW-1:0]  rsp_out_strip,
   output logic [shc_pkg::ClusW-1:0] rsp_cluster_number,
   output logic                      rsp_wide_cluster,
   output logic                      rsp_last_in_cluster,
   output logic                      rsp_last_of_event,
   output logic                      rsp_hits_dropped
);

   typedef enum logic [3:0] {
      S_IDLE, S_HIT_RD,
      S_OUTER, S_KEY_RD, S_CMP_RD, S_CMP, S_PLACE,
      S_LAB_RD, S_LAB, S_EMIT_RD, S_EMIT
   } state_type;

   state_type state_ff;
   logic [CntW-1:0]   count_ff;
   logic              ovf_ff;
   logic [CntW-1:0]   i_ff, j_ff;
   logic [EntryW-1:0] key_ff;
   logic [ValW-1:0]   hidx_ff;
   logic [ClusW-1:0]  clus_ff;
   logic [ValW-1:0]   prev_ff;
   logic              valid_ff;
   logic [ValW-1:0]   o_hit_ff, o_strip_ff;
   logic [ClusW-1:0]  o_clus_ff;
   logic              o_big_ff, o_lc_ff, o_le_ff, o_drop_ff;
   logic              chip_ok_ff;

   // per-hit cluster number table: small, read at one address
   logic              cl_we;
   logic [HitAw-1:0]  cl_wa, cl_ra;
   logic [ClusW-1:0]  cl_wd, cl_rd;
   logic [ClusW-1:0]  cl_next_ff;

   // strip map
   logic              map_we;
   logic [MapAw-1:0]  map_wa, map_ra;
   logic [ValW-1:0]   map_rd;
   // connector table
   logic              con_we;
   logic [ChipAw-1:0] con_wa;
   logic [ValW-1:0]   con_rd;
   // hit buffer
   logic              buf_we;
   logic [HitAw-1:0]  buf_wa, buf_ra;
   logic [EntryW-1:0] buf_wd, buf_rd;

   logic chip_ok;
   assign chip_ok = ({1'b0, req_chip_index} < (ChipW+1)'(NumChips));
   assign map_ra  = MapAw'({req_chip_index, req_channel});
   assign map_wa  = map_ra;
   assign con_wa  = ChipAw'(req_chip_index);

   shc_ram #(.Width(ValW), .Depth(NumChips * ChannelsPerChip)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(map_wa), .wr_data(req_table_value),
      .rd_addr(map_ra), .rd_data(map_rd));
   shc_ram #(.Width(ValW), .Depth(NumChips)) u_con (
      .clock(clock), .wr_en(con_we), .wr_addr(con_wa), .wr_data(req_table_value),
      .rd_addr(con_wa), .rd_data(con_rd));
   shc_ram #(.Width(EntryW), .Depth(MaxHits)) u_buf (
      .clock(clock), .wr_en(buf_we), .wr_addr(buf_wa), .wr_data(buf_wd),
      .rd_addr(buf_ra), .rd_data(buf_rd));
   shc_ram #(.Width(ClusW), .Depth(MaxHits)) u_cl (
      .clock(clock), .wr_en(cl_we), .wr_addr(cl_wa), .wr_data(cl_wd),
      .rd_addr(cl_ra), .rd_data(cl_rd));

   logic take;
   assign take = start && (state_ff == S_IDLE);
   assign busy = (state_ff != S_IDLE);

   logic [CntW-1:0] jm1;
   assign jm1 = j_ff - CntW'(1);

   // memory control
   always_comb begin
      map_we = take && (mode_type'(req_mode) == MODE_LOAD_MAP) && chip_ok;
      con_we = take && (mode_type'(req_mode) == MODE_LOAD_CONN) && chip_ok;
      buf_we = 1'b0;
      buf_wa = HitAw'(count_ff);
      buf_wd = {hidx_ff, map_rd};
      buf_ra = HitAw'(i_ff);
      cl_we  = 1'b0;
      cl_wa  = HitAw'(i_ff);
      cl_wd  = '0;
      cl_ra  = HitAw'(i_ff);
      unique case (state_ff)
         S_HIT_RD: begin
            buf_we = chip_ok_ff && con_rd[0] && (count_ff < CntW'(MaxHits));
         end
         S_CMP_RD: buf_ra = HitAw'(jm1);
         S_CMP: begin
            // shift the larger entry up one place
            buf_we = (j_ff != '0) && (buf_rd[ValW-1:0] > key_ff[ValW-1:0]);
            buf_wa = HitAw'(j_ff);
            buf_wd = buf_rd;
         end
         S_PLACE: begin
            buf_we = 1'b1;
            buf_wa = HitAw'(j_ff);
            buf_wd = key_ff;
         end
         S_LAB: begin
            cl_we = 1'b1;
            cl_wd = (i_ff == '0 || buf_rd[ValW-1:0] != prev_ff + ValW'(1))
                    ? ((i_ff == '0) ? ClusW'(0) : cl_next_ff + ClusW'(1))
                    : cl_next_ff;
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (take) begin
               hidx_ff    <= req_hit_index;
               chip_ok_ff <= chip_ok;
               i_ff       <= CntW'(1);
               priority case (mode_type'(req_mode))
                  MODE_HIT: state_ff <= S_HIT_RD;
                  MODE_END: begin
                     if (count_ff == '0) begin
                        ovf_ff <= 1'b0;
                     end else begin
                        state_ff <= S_OUTER;
                     end
                  end
                  default: ;
               endcase
            end
            // table reads are on the RAM outputs now: keep or drop the hit
            S_HIT_RD: begin
               if (chip_ok_ff && con_rd[0]) begin
                  if (count_ff < CntW'(MaxHits)) count_ff <= count_ff + CntW'(1);
                  else ovf_ff <= 1'b1;
               end
               state_ff <= S_IDLE;
            end
            // insertion sort, outer loop
            S_OUTER: begin
               if (i_ff >= count_ff) begin
                  i_ff     <= '0;
                  state_ff <= S_LAB_RD;
               end else begin
                  state_ff <= S_KEY_RD;
               end
            end
            S_KEY_RD: begin
               j_ff     <= i_ff;
               state_ff <= S_CMP_RD;
            end
            S_CMP_RD: begin
               if (j_ff == i_ff) key_ff <= buf_rd;
               if (j_ff == '0) state_ff <= S_PLACE;
               else state_ff <= S_CMP;
            end
            S_CMP: begin
               if (buf_rd[ValW-1:0] > key_ff[ValW-1:0]) begin
                  j_ff     <= jm1;
                  state_ff <= S_CMP_RD;
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: begin
               i_ff     <= i_ff + CntW'(1);
               state_ff <= S_OUTER;
            end
            // label pass: cluster number per hit
            S_LAB_RD: state_ff <= S_LAB;
            S_LAB: begin
               prev_ff <= buf_rd[ValW-1:0];
               if (i_ff != '0) begin
                  if (buf_rd[ValW-1:0] != prev_ff + ValW'(1)) begin
                     cl_next_ff <= cl_next_ff + ClusW'(1);
                  end
               end else begin
                  cl_next_ff <= '0;
               end
               if (i_ff + CntW'(1) >= count_ff) begin
                  i_ff     <= '0;
                  state_ff <= S_EMIT_RD;
               end else begin
                  i_ff     <= i_ff + CntW'(1);
                  state_ff <= S_LAB_RD;
               end
            end
            S_EMIT_RD: state_ff <= S_EMIT;
            S_EMIT: begin
               // hold the current hit one step to learn the next cluster;
               // a cluster is wide when a neighbor shares its number
               if (i_ff != '0) begin
                  valid_ff   <= 1'b1;
                  o_hit_ff   <= hidx_ff;
                  o_strip_ff <= prev_ff;
                  o_clus_ff  <= clus_ff;
                  o_big_ff   <= ((i_ff >= CntW'(2)) && (o_clus_ff == clus_ff))
                                || ((i_ff != count_ff) && (cl_rd == clus_ff));
                  o_lc_ff    <= (i_ff == count_ff) || (cl_rd != clus_ff);
                  o_le_ff    <= (i_ff == count_ff);
                  o_drop_ff  <= ovf_ff;
               end
               hidx_ff <= buf_rd[EntryW-1:ValW];
               prev_ff <= buf_rd[ValW-1:0];
               clus_ff <= cl_rd;
               if (i_ff == count_ff) begin
                  count_ff <= '0;
                  ovf_ff   <= 1'b0;
                  state_ff <= S_IDLE;
               end else begin
                  i_ff     <= i_ff + CntW'(1);
                  state_ff <= S_EMIT_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_out_hit_index   = o_hit_ff;
   assign rsp_out_strip       = o_strip_ff;
   assign rsp_cluster_number  = o_clus_ff;
   assign rsp_wide_cluster    = o_big_ff;
   assign rsp_last_in_cluster = o_lc_ff;
   assign rsp_last_of_event   = o_le_ff;
   assign rsp_hits_dropped    = o_drop_ff;

endmodule

@@ test/strip_hit_clusterer_core_tb.sv @@
module strip_hit_clusterer_core_tb;
   import shc_pkg::*;

   typedef struct {
      mode_type          mode;
      logic [ChipW-1:0]  chip;
      logic [ChanW-1:0]  chan;
      logic [ValW-1:0]   hidx;
      logic [ValW-1:0]   tval;
   } hit_item_type;

   typedef struct {
      logic [ValW-1:0]  hidx;
      logic [ValW-1:0]  strip;
      logic [ClusW-1:0] clus;
      logic             big;
      logic             last_c;
      logic             last_e;
      logic             dropped;
   } cluster_rec_type;

   localparam int MapDepth = NumChips * ChannelsPerChip;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0]       req_mode;
   logic [ChipW-1:0] req_chip_index;
   logic [ChanW-1:0] req_channel;
   logic [ValW-1:0]  req_hit_index;
   logic [ValW-1:0]  req_table_value;
   logic             rsp_valid;
   logic [ValW-1:0]  rsp_out_hit_index;
   logic [ValW-1:0]  rsp_out_strip;
   logic [ClusW-1:0] rsp_cluster_number;
   logic             rsp_wide_cluster;
   logic             rsp_last_in_cluster;
   logic             rsp_last_of_event;
   logic             rsp_hits_dropped;

   hit_item_type    pending_q[$];
   cluster_rec_type cluster_q[$];
   hit_item_type    cur_item;
   int           errors = 0;
   int           gap = 0;
   bit           no_idle = 0;

   // predictor state
   logic [ValW-1:0] pr_map [MapDepth];
   logic [ValW-1:0] pr_conn [NumChips];
   logic [ValW-1:0] pr_hidx [MaxHits];
   logic [ValW-1:0] pr_strip [MaxHits];
   int              pr_count = 0;
   bit              pr_over = 0;

   // generator bookkeeping: which entries hold a value
   bit              gen_map_set [MapDepth];
   int              gen_pool[$];

   strip_hit_clusterer_core DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // apply one accepted item and queue the cluster records it causes
   task automatic cluster_predict(input hit_item_type it);
      int addr;
      int n;
      int c;
      int j;
      int cid [MaxHits];
      int csize [MaxHits];
      logic [ValW-1:0] h;
      logic [ValW-1:0] s;
      cluster_rec_type r;
      addr = int'(it.chan) + ChannelsPerChip * int'(it.chip);
      case (it.mode)
         MODE_LOAD_MAP:  pr_map[addr] = it.tval;
         MODE_LOAD_CONN: pr_conn[it.chip] = it.tval;
         MODE_HIT: begin
            if (pr_conn[it.chip][0]) begin
               if (pr_count >= MaxHits) pr_over = 1;
               else begin
                  pr_hidx[pr_count] = it.hidx;
                  pr_strip[pr_count] = pr_map[addr];
                  pr_count++;
               end
            end
         end
         default: begin
            n = pr_count;
            // stable insertion sort by strip
            for (int i = 1; i < n; i++) begin
               h = pr_hidx[i];
               s = pr_strip[i];
               j = i;
               while (j > 0 && pr_strip[j-1] > s) begin
                  pr_hidx[j] = pr_hidx[j-1];
                  pr_strip[j] = pr_strip[j-1];
                  j--;
               end
               pr_hidx[j] = h;
               pr_strip[j] = s;
            end
            c = 0;
            for (int i = 0; i < MaxHits; i++) csize[i] = 0;
            for (int i = 0; i < n; i++) begin
               if (i > 0 && int'(pr_strip[i]) != int'(pr_strip[i-1]) + 1) c++;
               cid[i] = c;
               csize[c]++;
            end
            for (int i = 0; i < n; i++) begin
               r.hidx    = pr_hidx[i];
               r.strip   = pr_strip[i];
               r.clus    = ClusW'(cid[i]);
               r.big     = csize[cid[i]] > 1;
               r.last_c  = (i + 1 == n) || (cid[i+1] != cid[i]);
               r.last_e  = (i + 1 == n);
               r.dropped = pr_over;
               cluster_q.insert(cluster_q.size(), r);
            end
            pr_count = 0;
            pr_over = 0;
         end
      endcase
   endtask

   function automatic void add_item(input mode_type m, input int chip, input int chan,
                                    input int hidx, input int tval);
      hit_item_type it;
      it.mode = m;
      it.chip = ChipW'(chip);
      it.chan = ChanW'(chan);
      it.hidx = ValW'(hidx);
      it.tval = ValW'(tval);
      if (m == MODE_LOAD_MAP && !gen_map_set[chan + ChannelsPerChip * chip]) begin
         gen_map_set[chan + ChannelsPerChip * chip] = 1;
         gen_pool.insert(gen_pool.size(), chan + ChannelsPerChip * chip);
      end
      pending_q.insert(pending_q.size(), it);
   endfunction

   // hit on a random loaded map entry
   function automatic void add_pool_hit();
      int a;
      a = gen_pool[$urandom_range(0, gen_pool.size() - 1)];
      add_item(MODE_HIT, a / ChannelsPerChip, a % ChannelsPerChip, $urandom_range(0, 4095),
               $urandom_range(0, 4095));
   endfunction

   function automatic int near_strip();
      int p;
      p = $urandom_range(0, 19);
      if (p == 0) return 0;
      if (p == 1) return 4095;
      if (p == 2) return $urandom_range(0, 4095);
      return $urandom_range(100, 124);
   endfunction

   // drive items; each transfer feeds the predictor
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (!start || !busy) begin
         if (start) begin
            cluster_predict(cur_item);
            if (cur_item.mode == MODE_END) no_idle = ($urandom_range(0, 3) == 0);
            gap = no_idle ? 0 : $urandom_range(0, 11);
         end
         if (gap > 0) begin
            gap--;
            start <= 0;
         end else if (pending_q.size() > 0) begin
            cur_item = pending_q.pop_front();
            req_mode <= cur_item.mode;
            req_chip_index <= cur_item.chip;
            req_channel <= cur_item.chan;
            req_hit_index <= cur_item.hidx;
            req_table_value <= cur_item.tval;
            start <= 1;
         end else begin
            start <= 0;
         end
      end
   end

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // compare each result transfer with the oldest expected record
   always @(posedge clock) begin
      cluster_rec_type e;
      if (!reset && rsp_valid) begin
         if (cluster_q.size() == 0) begin
            $display("%0t: unexpected result, expected none actual hit %0d", $time,
                     rsp_out_hit_index);
            errors++;
         end else begin
            e = cluster_q.pop_front();
            check_field("hit_index", int'(e.hidx), int'(rsp_out_hit_index));
            check_field("strip", int'(e.strip), int'(rsp_out_strip));
            check_field("cluster_number", int'(e.clus), int'(rsp_cluster_number));
            check_field("wide_cluster", int'(e.big), int'(rsp_wide_cluster));
            check_field("last_in_cluster", int'(e.last_c), int'(rsp_last_in_cluster));
            check_field("last_of_event", int'(e.last_e), int'(rsp_last_of_event));
            check_field("hits_dropped", int'(e.dropped), int'(rsp_hits_dropped));
         end
      end
   end

   initial begin
      int k;
      start = 0;
      req_mode = MODE_LOAD_MAP;
      req_chip_index = 0;
      req_channel = 0;
      req_hit_index = 0;
      req_table_value = 0;
      reset = 1;

      // connectors for every chip: chip 2 even (hits discarded), extremes on 0 and 15
      for (int c = 0; c < NumChips; c++)
         add_item(MODE_LOAD_CONN, c, 0, 0,
                  c == 2 ? 0 : c == 15 ? 4095 : c == 0 ? 1 : ($urandom_range(0, 2047) * 2 + 1));
      add_item(MODE_LOAD_MAP, 0, 0, 0, 0);
      add_item(MODE_LOAD_MAP, 15, 127, 0, 4095);
      add_item(MODE_LOAD_MAP, 1, 5, 0, 100);
      add_item(MODE_LOAD_MAP, 1, 6, 0, 101);
      add_item(MODE_LOAD_MAP, 3, 9, 0, 101);
      add_item(MODE_LOAD_MAP, 2, 64, 0, 102);
      // edge strips, equal strips, adjacency run and an even connector hit
      add_item(MODE_HIT, 15, 127, 4095, 0);
      add_item(MODE_HIT, 0, 0, 0, 0);
      add_item(MODE_HIT, 1, 5, 17, 0);
      add_item(MODE_HIT, 3, 9, 18, 0);
      add_item(MODE_HIT, 1, 6, 19, 0);
      add_item(MODE_HIT, 2, 64, 20, 0);
      add_item(MODE_END, 0, 0, 0, 0);
      add_item(MODE_END, 0, 0, 0, 0);
      // map change mid-event
      add_item(MODE_HIT, 1, 5, 21, 0);
      add_item(MODE_LOAD_MAP, 1, 5, 0, 200);
      add_item(MODE_HIT, 1, 5, 22, 0);
      add_item(MODE_END, 0, 0, 0, 0);

      // random: mostly well-formed events, some table traffic
      while (pending_q.size() < 400) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               k = $urandom_range(1, 6);
               repeat (k) add_item(MODE_LOAD_MAP, $urandom_range(0, 15), $urandom_range(0, 127),
                                   $urandom_range(0, 4095), near_strip());
            end
            2: add_item(MODE_LOAD_CONN, $urandom_range(0, 15), 0, $urandom_range(0, 4095),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                    : ($urandom_range(0, 2047) * 2 + 1));
            default: begin
               k = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 9);
               repeat (k) begin
                  if ($urandom_range(0, 19) == 0)
                     add_item(MODE_LOAD_MAP, $urandom_range(0, 15), $urandom_range(0, 127),
                              $urandom_range(0, 4095), near_strip());
                  add_pool_hit();
               end
               add_item(MODE_END, $urandom_range(0, 15), $urandom_range(0, 127),
                        $urandom_range(0, 4095), $urandom_range(0, 4095));
            end
         endcase
      end

      repeat (8) @(posedge clock);
      reset <= 0;

      wait (pending_q.size() == 0 && !start);
      wait (cluster_q.size() == 0 && !busy);
      repeat (50) @(posedge clock);
      if (errors == 0 && cluster_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #30000000;
      $display("tb: failure");
      $finish;
   end

endmodule
